// ===== rtl/nsfc_pkg.sv =====
// Package for the NMEA sentence framer and checksum checker.
// Holds character codes and the hex digit decode type; no dependencies.
`default_nettype none
package nsfc_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_STAR   = 8'h2a;

  localparam logic [1:0] STAR_CNT_MAX = 2'd2;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } hex_t;

endpackage
`default_nettype wire

// ===== rtl/nsfc_hex_digit.sv =====
// Decode one ASCII character as a hex digit of either case.
// Uses nsfc_pkg::hex_t for the result.
`default_nettype none
module nsfc_hex_digit (
  input  wire logic [7:0]    ch,
  output nsfc_pkg::hex_t     dig
);

  always_comb begin
    dig.is_hex = 1'b0;
    dig.nibble = 4'd0;
    if (ch >= 8'd48 && ch <= 8'd57) begin
      dig.is_hex = 1'b1;
      dig.nibble = ch[3:0];
    end else if ((ch >= 8'd65 && ch <= 8'd70) || (ch >= 8'd97 && ch <= 8'd102)) begin
      dig.is_hex = 1'b1;
      dig.nibble = 4'(ch[3:0] + 4'd9);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/nmea_sentence_framer_checker.sv =====
// NMEA sentence framer and XOR checksum checker, one received byte per word.
// The result is valid in the cycle after input accept (single result register).
// Throughput: one word per cycle; input stays ready while the result register
// is empty or being drained in the same cycle.
// Reset: synchronous, active high; clears framing state and the result valid.
// Depends on nsfc_pkg and nsfc_hex_digit.
`default_nettype none
module nmea_sentence_framer_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      byte_echo,
  output logic            byte_kept,
  output logic            sentence_start,
  output logic            sentence_end,
  output logic            checksum_ok,
  output logic [7:0]      computed_sum,
  output logic [7:0]      received_sum
);

  logic       in_sentence, in_sentence_next;
  logic       cr_pending, cr_pending_next;
  logic       star_seen, star_seen_next;
  logic [7:0] xor_accum, xor_accum_next;
  logic [1:0] chars_after_star, chars_after_star_next;
  logic [3:0] first_nibble, first_nibble_next;
  logic       first_is_hex, first_is_hex_next;
  logic [3:0] second_nibble, second_nibble_next;
  logic       second_is_hex, second_is_hex_next;

  logic       in_fire;
  logic       kept, start, close, ok;
  logic [7:0] recv;
  nsfc_pkg::hex_t dig;

  nsfc_hex_digit u_hex (
    .ch  (rx_byte),
    .dig (dig)
  );

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    in_sentence_next      = in_sentence;
    cr_pending_next       = cr_pending;
    star_seen_next        = star_seen;
    xor_accum_next        = xor_accum;
    chars_after_star_next = chars_after_star;
    first_nibble_next     = first_nibble;
    first_is_hex_next     = first_is_hex;
    second_nibble_next    = second_nibble;
    second_is_hex_next    = second_is_hex;
    kept  = 1'b0;
    start = 1'b0;
    close = 1'b0;
    recv  = 8'd0;
    ok    = 1'b0;

    if (rx_byte == nsfc_pkg::CH_DOLLAR) begin
      in_sentence_next      = 1'b1;
      cr_pending_next       = 1'b0;
      star_seen_next        = 1'b0;
      xor_accum_next        = 8'd0;
      chars_after_star_next = 2'd0;
      first_nibble_next     = 4'd0;
      first_is_hex_next     = 1'b0;
      second_nibble_next    = 4'd0;
      second_is_hex_next    = 1'b0;
      kept  = 1'b1;
      start = 1'b1;
    end else if (rx_byte == nsfc_pkg::CH_CR) begin
      if (in_sentence) begin
        cr_pending_next = 1'b1;
      end
    end else if (rx_byte == nsfc_pkg::CH_LF) begin
      close = in_sentence && cr_pending;
    end else if (in_sentence) begin
      kept = 1'b1;
      cr_pending_next = 1'b0;
      if (star_seen) begin
        if (chars_after_star == 2'd0) begin
          first_nibble_next = dig.nibble;
          first_is_hex_next = dig.is_hex;
        end else if (chars_after_star == 2'd1) begin
          second_nibble_next = dig.nibble;
          second_is_hex_next = dig.is_hex;
        end
        if (chars_after_star != nsfc_pkg::STAR_CNT_MAX) begin
          chars_after_star_next = 2'(chars_after_star + 2'd1);
        end
      end else if (rx_byte == nsfc_pkg::CH_STAR) begin
        star_seen_next = 1'b1;
      end else begin
        xor_accum_next = xor_accum ^ rx_byte;
      end
    end

    if (chars_after_star_next != 2'd0 && first_is_hex_next) begin
      if (chars_after_star_next == nsfc_pkg::STAR_CNT_MAX && second_is_hex_next) begin
        recv = {first_nibble_next, second_nibble_next};
      end else begin
        recv = {4'd0, first_nibble_next};
      end
    end

    ok = close && star_seen_next && (chars_after_star_next == nsfc_pkg::STAR_CNT_MAX) &&
         first_is_hex_next && (xor_accum_next == recv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence      <= 1'b0;
      cr_pending       <= 1'b0;
      star_seen        <= 1'b0;
      xor_accum        <= 8'd0;
      chars_after_star <= 2'd0;
      first_nibble     <= 4'd0;
      first_is_hex     <= 1'b0;
      second_nibble    <= 4'd0;
      second_is_hex    <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (in_fire) begin
        if (close) begin
          in_sentence      <= 1'b0;
          cr_pending       <= 1'b0;
          star_seen        <= 1'b0;
          xor_accum        <= 8'd0;
          chars_after_star <= 2'd0;
          first_nibble     <= 4'd0;
          first_is_hex     <= 1'b0;
          second_nibble    <= 4'd0;
          second_is_hex    <= 1'b0;
        end else begin
          in_sentence      <= in_sentence_next;
          cr_pending       <= cr_pending_next;
          star_seen        <= star_seen_next;
          xor_accum        <= xor_accum_next;
          chars_after_star <= chars_after_star_next;
          first_nibble     <= first_nibble_next;
          first_is_hex     <= first_is_hex_next;
          second_nibble    <= second_nibble_next;
          second_is_hex    <= second_is_hex_next;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_echo      <= rx_byte;
      byte_kept      <= kept;
      sentence_start <= start;
      sentence_end   <= close;
      checksum_ok    <= ok;
      computed_sum   <= xor_accum_next;
      received_sum   <= recv;
    end
  end

  a_star_cnt_sat: assert property (@(posedge clk) disable iff (rst)
    chars_after_star != 2'd3)
    else $error("chars after star exceeded saturation");

  a_cnt_needs_star: assert property (@(posedge clk) disable iff (rst)
    !star_seen |-> chars_after_star == 2'd0)
    else $error("chars counted without a star");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && close |=> !in_sentence && !star_seen && xor_accum == 8'd0)
    else $error("sentence state not cleared at close");

  a_ok_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && checksum_ok |-> sentence_end && !byte_kept)
    else $error("checksum verdict outside a close");

  a_pending_in_sentence: assert property (@(posedge clk) disable iff (rst)
    cr_pending |-> in_sentence)
    else $error("end mark set outside a sentence");

endmodule
`default_nettype wire
